// ===== rtl/core/spsc_pkg.sv =====
package spsc_pkg;

  // Default sizes
  localparam int CHANNELS_DEF = 5;
  localparam int PRESETS_DEF  = 8;

  // Reset values and step limits
  localparam logic [15:0] CENTER_RESET = 16'd3000;
  localparam logic [7:0]  PERIOD_RESET = 8'd2;
  localparam logic [6:0]  STEP_DEFAULT = 7'd50;
  localparam logic [6:0]  STEP_MIN     = 7'd1;
  localparam logic [6:0]  STEP_MAX     = 7'd100;

  // Configuration register indexes
  localparam logic REG_SLEW_PERIOD = 1'b0;

  // Follow mode that copies the master's presets and step
  localparam logic [1:0] FOLLOW_COPY = 2'd1;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_MOVE       = 3'd1,
    OP_SET_PRESET = 3'd2,
    OP_SET_STEP   = 3'd3,
    OP_SET_FOLLOW = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_MOVE
  } state_t;

  // Per-channel slew state handed to the shared slew unit
  typedef struct packed {
    logic [15:0] actual;
    logic [15:0] target;
    logic [6:0]  step;
    logic        running;
    logic [7:0]  count;
  } chan_state_t;

  // Updated channel state from the slew unit
  typedef struct packed {
    logic [15:0] actual;
    logic        running;
    logic [7:0]  count;
  } chan_update_t;

endpackage

// ===== rtl/core/servo_preset_slew_controller_core.sv =====
// Tick: busy while the channels are walked, one channel per cycle; results one per cycle on strobe,
//   each registered from the tick state; the next item is accepted only once busy drops.
// Move: busy while the preset memory is read. Set preset, set step
//   and set follow finish in the accept cycle. The receiver cannot stall results.
// Reset (rst, synchronous): presets and positions to center 3000, steps to 50,
//   follow off, no masters, all channels steady, slew period 2.
module servo_preset_slew_controller_core #(
  parameter int CHANNELS = spsc_pkg::CHANNELS_DEF,
  parameter int PRESETS  = spsc_pkg::PRESETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [2:0]  channel,
  input  logic [2:0]  preset,
  input  logic [15:0] pulse,
  input  logic [6:0]  step,
  input  logic [1:0]  follow_mode,
  input  logic [2:0]  master,
  input  logic        master_valid,
  output logic        strobe,
  output logic [2:0]  out_channel,
  output logic [15:0] out_pulse,
  output logic        moving,
  output logic        last,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data
);
  import spsc_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * PRESETS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;

  logic [7:0] slew_period;

  logic [15:0] actual      [CHANNELS];
  logic [15:0] target      [CHANNELS];
  logic [6:0]  active_step [CHANNELS];
  logic        running     [CHANNELS];
  logic [7:0]  tick_cnt    [CHANNELS];
  logic [6:0]  step_tbl    [CHANNELS];
  logic [1:0]  follow_tbl  [CHANNELS];
  logic        master_vld  [CHANNELS];
  logic [CH_W-1:0] master_idx [CHANNELS];

  logic [CH_W-1:0] idx;
  logic [CH_W-1:0] mv_ch;

  logic            accept;
  logic            ch_ok;
  logic            pr_ok;
  logic [CH_W-1:0] ch_i;
  logic [CH_W-1:0] src;
  logic [6:0]      step_sat;
  logic            do_move;
  logic            do_set;
  logic            do_step;
  logic            do_follow;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [15:0]     rd_data;

  chan_state_t  cur;
  chan_update_t upd;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Command decode
  assign ch_ok = (int'(channel) < CHANNELS);
  assign pr_ok = (int'(preset) < PRESETS);
  assign ch_i  = CH_W'(channel);

  always_comb begin
    do_move   = 1'b0;
    do_set    = 1'b0;
    do_step   = 1'b0;
    do_follow = 1'b0;
    if (accept && ch_ok) begin
      unique case (op)
        OP_MOVE:       do_move   = pr_ok;
        OP_SET_PRESET: do_set    = pr_ok;
        OP_SET_STEP:   do_step   = 1'b1;
        OP_SET_FOLLOW: do_follow = 1'b1;
        default:       ;
      endcase
    end
  end

  // Move source channel: master when copy-follow with a master assigned
  assign src = (follow_tbl[ch_i] == FOLLOW_COPY && master_vld[ch_i]) ?
               master_idx[ch_i] : ch_i;

  assign rd_addr = AW'(int'(src) * PRESETS + int'(preset));
  assign wr_addr = AW'(int'(ch_i) * PRESETS + int'(preset));

  always_comb begin
    if (step < STEP_MIN) begin
      step_sat = STEP_MIN;
    end else if (step > STEP_MAX) begin
      step_sat = STEP_MAX;
    end else begin
      step_sat = step;
    end
  end

  spsc_preset_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (do_set),
    .wr_addr (wr_addr),
    .wr_data (pulse),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared slew unit, one channel per cycle
  always_comb begin
    cur.actual  = actual[idx];
    cur.target  = target[idx];
    cur.step    = active_step[idx];
    cur.running = running[idx];
    cur.count   = tick_cnt[idx];
  end

  spsc_slew_unit u_slew (
    .cur    (cur),
    .period (slew_period),
    .upd    (upd)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && op == OP_TICK) begin
          state_next = ST_TICK;
        end else if (do_move) begin
          state_next = ST_MOVE;
        end
      end
      ST_TICK: begin
        if (idx == CH_W'(CHANNELS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_MOVE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Channel walk index and move channel
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      mv_ch <= '0;
    end else begin
      if (state == ST_TICK) begin
        idx <= (idx == CH_W'(CHANNELS - 1)) ? '0 : idx + CH_W'(1);
      end
      if (do_move) begin
        mv_ch <= ch_i;
      end
    end
  end

  // Slew period register
  always_ff @(posedge clk) begin
    if (rst) begin
      slew_period <= PERIOD_RESET;
    end else if (wr_en && wr_index == REG_SLEW_PERIOD) begin
      slew_period <= wr_data[7:0];
    end
  end

  // Channel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        actual[c]      <= CENTER_RESET;
        target[c]      <= CENTER_RESET;
        active_step[c] <= STEP_DEFAULT;
        running[c]     <= 1'b0;
        tick_cnt[c]    <= 8'd0;
        step_tbl[c]    <= STEP_DEFAULT;
        follow_tbl[c]  <= 2'd0;
        master_vld[c]  <= 1'b0;
        master_idx[c]  <= '0;
      end
    end else begin
      if (state == ST_TICK) begin
        actual[idx]   <= upd.actual;
        running[idx]  <= upd.running;
        tick_cnt[idx] <= upd.count;
      end
      if (state == ST_MOVE) begin
        target[mv_ch] <= rd_data;
      end
      if (do_move) begin
        active_step[ch_i] <= step_tbl[src];
      end
      if (do_set) begin
        actual[ch_i] <= pulse;
        target[ch_i] <= pulse;
      end
      if (do_step) begin
        step_tbl[ch_i] <= step_sat;
      end
      if (do_follow) begin
        follow_tbl[ch_i] <= follow_mode;
        master_vld[ch_i] <= master_valid && (int'(master) < CHANNELS);
        master_idx[ch_i] <= CH_W'(master);
      end
    end
  end

  // Result register: one item per channel during a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == ST_TICK);
    end
  end

  always_ff @(posedge clk) begin
    out_channel <= 3'(idx);
    out_pulse   <= upd.actual;
    moving      <= upd.running;
    last        <= (idx == CH_W'(CHANNELS - 1));
  end

endmodule

// ===== rtl/core/spsc_slew_unit.sv =====
module spsc_slew_unit (
  input  spsc_pkg::chan_state_t  cur,
  input  logic [7:0]             period,
  output spsc_pkg::chan_update_t upd
);
  import spsc_pkg::*;

  logic [7:0]  cnt_inc;
  logic [16:0] up_sum;
  logic [16:0] tgt_sum;
  logic [15:0] slewed;
  logic        at_target;
  logic        fire;

  assign cnt_inc   = cur.count + 8'd1;
  assign at_target = (cur.actual == cur.target);
  assign fire      = (cnt_inc == period);

  // One step toward target, snap when within one step
  assign up_sum  = {1'b0, cur.actual} + {10'd0, cur.step};
  assign tgt_sum = {1'b0, cur.target} + {10'd0, cur.step};

  always_comb begin
    if ({1'b0, cur.target} > up_sum) begin
      slewed = up_sum[15:0];
    end else if (tgt_sum < {1'b0, cur.actual}) begin
      slewed = cur.actual - {9'd0, cur.step};
    end else begin
      slewed = cur.target;
    end
  end

  // Run state, step timing and tick counter
  always_comb begin
    upd.actual  = cur.actual;
    upd.running = cur.running;
    upd.count   = cnt_inc;
    if (!cur.running) begin
      if (!at_target) begin
        upd.running = 1'b1;
        upd.count   = 8'd0;
      end
    end else begin
      if (fire) begin
        upd.actual = slewed;
        upd.count  = 8'd0;
      end
      if (at_target) begin
        upd.running = 1'b0;
        upd.count   = 8'd0;
      end
    end
  end

endmodule

// ===== rtl/core/spsc_preset_mem.sv =====
module spsc_preset_mem #(
  parameter int DEPTH = 40,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);
  import spsc_pkg::*;

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [15:0]      rd_raw;
  logic             rd_hit;

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  // Entry valid bits; an unwritten entry reads as the reset center
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_hit <= vld[rd_addr];
    end
  end

  assign rd_data = rd_hit ? rd_raw : CENTER_RESET;

endmodule
